// File: design/sab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_pkg
// Shared widths and memory request types for the suffix automaton builder.
// ----------------------------------------------------------------------------
package sab_pkg;

  // Width of a stored state length and of the narrow result fields.
  localparam int LEN_W   = 11;
  localparam int IDX_W   = 11;
  localparam int COUNT_W = 12;
  localparam int IN_W    = 8;

  // Request to the node store (length and suffix link per state).
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } node_req_t;

  // Request to the transition store; row_wr writes a whole row at once.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic row_wr;
  } trans_req_t;

endpackage

// File: design/sab_node_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_node_mem
// Per-state store of longest length and suffix link, one read and one write
// port, registered read data.
// ----------------------------------------------------------------------------
module sab_node_mem #(
  parameter int DEPTH = 2048,
  parameter int SW    = 11
) (
  input  logic                    clk,
  input  sab_pkg::node_req_t      req,
  input  logic [SW-1:0]           raddr,
  input  logic [SW-1:0]           waddr,
  input  logic [sab_pkg::LEN_W-1:0] wlen,
  input  logic [SW-1:0]           wlink,
  output logic [sab_pkg::LEN_W-1:0] rlen,
  output logic [SW-1:0]           rlink
);

  logic [sab_pkg::LEN_W-1:0] len_mem [DEPTH];
  logic [SW-1:0]             link_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      len_mem[waddr]  <= wlen;
      link_mem[waddr] <= wlink;
    end
    if (req.rd_en) begin
      rlen  <= len_mem[raddr];
      rlink <= link_mem[raddr];
    end
  end

endmodule

// File: design/sab_trans_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_trans_mem
// Transition store organised as one row per state, one lane per letter.
// A write either sets one lane valid with a target or replaces a whole row.
// ----------------------------------------------------------------------------
module sab_trans_mem #(
  parameter int DEPTH = 2048,
  parameter int SW    = 11,
  parameter int LB    = 8
) (
  input  logic                            clk,
  input  sab_pkg::trans_req_t             req,
  input  logic [SW-1:0]                   raddr,
  input  logic [SW-1:0]                   waddr,
  input  logic [LB-1:0]                   wlane,
  input  logic [SW-1:0]                   wtgt,
  input  logic [(1<<LB)-1:0]              wrow_valid,
  input  logic [(1<<LB)-1:0][SW-1:0]      wrow_tgt,
  output logic [(1<<LB)-1:0]              rrow_valid,
  output logic [(1<<LB)-1:0][SW-1:0]      rrow_tgt
);

  logic [(1<<LB)-1:0]         val_mem [DEPTH];
  logic [(1<<LB)-1:0][SW-1:0] tgt_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      if (req.row_wr) begin
        val_mem[waddr] <= wrow_valid;
        tgt_mem[waddr] <= wrow_tgt;
      end else begin
        val_mem[waddr][wlane] <= 1'b1;
        tgt_mem[waddr][wlane] <= wtgt;
      end
    end
    if (req.rd_en) begin
      rrow_valid <= val_mem[raddr];
      rrow_tgt   <= tgt_mem[raddr];
    end
  end

endmodule

// File: design/suffix_automaton_builder.sv
`timescale 1ns / 1ps
// Each letter reads its last state, creates the new state and walks suffix
// links, reading the single read port of each state store once per step,
// until a transition on the letter is found; a clone adds its writes and a
// redirect step per moved transition; an overflowed letter goes straight to
// the result. One letter is taken at a time, the next only once the last
// result is handed over. Reset: synchronous; an initialisation state writes
// the root before the first request is taken.
// ----------------------------------------------------------------------------
// suffix_automaton_builder
// Online suffix automaton construction with state data held in two
// synchronous memories and a sequencer that walks suffix links.
// ----------------------------------------------------------------------------
module suffix_automaton_builder #(
  parameter int MAX_LETTERS = 1024,
  parameter int LETTER_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sab_pkg::IN_W-1:0]      letter,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sab_pkg::IDX_W-1:0]     new_state,
  output logic [sab_pkg::LEN_W-1:0]     state_length,
  output logic [sab_pkg::IDX_W-1:0]     suffix_link,
  output logic                          cloned,
  output logic [sab_pkg::IDX_W-1:0]     clone_state,
  output logic [sab_pkg::COUNT_W-1:0]   state_count,
  output logic                          overflow
);

  // The store holds two states per letter: the new state and a possible clone.
  localparam int MAX_STATES = 2 * MAX_LETTERS;
  localparam int SW         = $clog2(MAX_STATES);
  localparam int NW         = $clog2(MAX_STATES + 1);
  localparam int STW        = $clog2(MAX_STATES + 2);
  localparam int ALPHA      = 1 << LETTER_BITS;
  localparam int LW         = sab_pkg::LEN_W;

  // Sequencer states.
  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_LEN  = 4'd2;
  localparam logic [3:0] S_WALK = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_QCHK = 4'd5;
  localparam logic [3:0] S_CL1  = 4'd6;
  localparam logic [3:0] S_CL2  = 4'd7;
  localparam logic [3:0] S_RED  = 4'd8;
  localparam logic [3:0] S_RRD  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]             state;
  logic [NW-1:0]          node_total;
  logic [SW-1:0]          last_state;
  logic [SW-1:0]          p;
  logic [SW-1:0]          q;
  logic [SW-1:0]          cur;
  logic [SW-1:0]          clone;
  logic [LETTER_BITS-1:0] c;
  logic [LW-1:0]          len_cur;
  logic [LW-1:0]          len_p;
  logic [LW-1:0]          len_q;
  logic [SW-1:0]          link_cur;
  logic                   made_clone;
  logic                   ovf;
  logic [STW-1:0]         steps;

  // Memory requests and data.
  sab_pkg::node_req_t          n_req;
  logic [SW-1:0]               n_raddr;
  logic [SW-1:0]               n_waddr;
  logic [LW-1:0]               n_wlen;
  logic [SW-1:0]               n_wlink;
  logic [LW-1:0]               n_rlen;
  logic [SW-1:0]               n_rlink;

  sab_pkg::trans_req_t         t_req;
  logic [SW-1:0]               t_raddr;
  logic [SW-1:0]               t_waddr;
  logic [SW-1:0]               t_wtgt;
  logic [ALPHA-1:0]            t_wrow_valid;
  logic [ALPHA-1:0]            t_rrow_valid;
  logic [ALPHA-1:0][SW-1:0]    t_rrow_tgt;

  logic                        lane_valid;
  logic [SW-1:0]               lane_tgt;
  logic                        full;
  logic                        step_ok;
  logic                        len_match;
  logic                        out_free;

  assign lane_valid = t_rrow_valid[c];
  assign lane_tgt   = t_rrow_tgt[c];
  // A letter is added only if both a new state and a clone still fit; else it is reported as an overflow.
  assign full       = ({1'b0, node_total} + (NW+1)'(2)) > (NW+1)'(MAX_STATES);
  assign step_ok    = steps <= STW'(MAX_STATES);
  assign len_match  = {1'b0, n_rlen} == ({1'b0, len_p} + (LW+1)'(1));
  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == S_IDLE);

  sab_node_mem #(.DEPTH(MAX_STATES), .SW(SW)) u_node (
    .clk   (clk),
    .req   (n_req),
    .raddr (n_raddr),
    .waddr (n_waddr),
    .wlen  (n_wlen),
    .wlink (n_wlink),
    .rlen  (n_rlen),
    .rlink (n_rlink)
  );

  sab_trans_mem #(.DEPTH(MAX_STATES), .SW(SW), .LB(LETTER_BITS)) u_trans (
    .clk        (clk),
    .req        (t_req),
    .raddr      (t_raddr),
    .waddr      (t_waddr),
    .wlane      (c),
    .wtgt       (t_wtgt),
    .wrow_valid (t_wrow_valid),
    .wrow_tgt   (t_rrow_tgt),
    .rrow_valid (t_rrow_valid),
    .rrow_tgt   (t_rrow_tgt)
  );

  // Memory request decode. Every read is issued in a later cycle than the
  // write it depends on, so no forwarding path is needed.
  always_comb begin
    n_req        = '0;
    n_raddr      = p;
    n_waddr      = cur;
    n_wlen       = len_cur;
    n_wlink      = p;
    t_req        = '0;
    t_raddr      = p;
    t_waddr      = p;
    t_wtgt       = cur;
    t_wrow_valid = t_rrow_valid;
    unique case (state) inside
      S_INIT: begin
        // The root has length zero, links to itself and has no transitions.
        n_req.wr_en  = 1'b1;
        n_waddr      = '0;
        n_wlen       = '0;
        n_wlink      = '0;
        t_req.wr_en  = 1'b1;
        t_req.row_wr = 1'b1;
        t_waddr      = '0;
        t_wrow_valid = '0;
      end
      S_IDLE: begin
        if (in_valid && !full) begin
          n_req.rd_en = 1'b1;
          n_raddr     = last_state;
          t_req.rd_en = 1'b1;
          t_raddr     = last_state;
        end
      end
      S_LEN: begin
        // Create the new state and give it an empty transition row.
        n_req.wr_en  = 1'b1;
        n_wlen       = n_rlen + LW'(1);
        n_wlink      = '0;
        t_req.wr_en  = 1'b1;
        t_req.row_wr = 1'b1;
        t_waddr      = cur;
        t_wrow_valid = '0;
      end
      S_WALK: begin
        if (!lane_valid && step_ok) begin
          t_req.wr_en = 1'b1;
        end else if (lane_tgt == cur) begin
          n_req.wr_en = 1'b1;
        end else begin
          n_req.rd_en = 1'b1;
          n_raddr     = lane_tgt;
          t_req.rd_en = 1'b1;
          t_raddr     = lane_tgt;
        end
      end
      S_RD, S_RRD: begin
        n_req.rd_en = 1'b1;
        t_req.rd_en = 1'b1;
      end
      S_QCHK: begin
        n_req.wr_en = 1'b1;
        if (len_match) begin
          n_wlink = q;
        end else begin
          // The clone takes the length p plus one, the link of q and a copy
          // of the row of q.
          n_waddr      = node_total[SW-1:0];
          n_wlen       = len_p + LW'(1);
          n_wlink      = n_rlink;
          t_req.wr_en  = 1'b1;
          t_req.row_wr = 1'b1;
          t_waddr      = node_total[SW-1:0];
        end
      end
      S_CL1: begin
        n_req.wr_en = 1'b1;
        n_waddr     = q;
        n_wlen      = len_q;
        n_wlink     = clone;
      end
      S_CL2: begin
        n_req.wr_en = 1'b1;
        n_wlink     = clone;
        n_req.rd_en = 1'b1;
        t_req.rd_en = 1'b1;
      end
      S_RED: begin
        if (lane_valid && (lane_tgt == q) && step_ok) begin
          t_req.wr_en = 1'b1;
          t_wtgt      = clone;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer and bookkeeping registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      node_total <= NW'(1);
      last_state <= '0;
      out_valid  <= 1'b0;
    end else begin
      // A result is raised as it is handed over and dropped once taken.
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            c          <= letter[LETTER_BITS-1:0];
            made_clone <= 1'b0;
            clone      <= '0;
            steps      <= '0;
            if (full) begin
              ovf      <= 1'b1;
              cur      <= '0;
              len_cur  <= '0;
              link_cur <= '0;
              state    <= S_DONE;
            end else begin
              ovf        <= 1'b0;
              p          <= last_state;
              cur        <= node_total[SW-1:0];
              last_state <= node_total[SW-1:0];
              node_total <= node_total + NW'(1);
              state      <= S_LEN;
            end
          end
        end
        S_LEN: begin
          len_cur <= n_rlen + LW'(1);
          state   <= S_WALK;
        end
        S_WALK: begin
          if (!lane_valid && step_ok) begin
            p     <= n_rlink;
            steps <= steps + STW'(1);
            state <= S_RD;
          end else if (lane_tgt == cur) begin
            link_cur <= p;
            state    <= S_DONE;
          end else begin
            q     <= lane_tgt;
            len_p <= n_rlen;
            state <= S_QCHK;
          end
        end
        S_RD: begin
          state <= S_WALK;
        end
        S_QCHK: begin
          if (len_match) begin
            link_cur <= q;
            state    <= S_DONE;
          end else begin
            made_clone <= 1'b1;
            clone      <= node_total[SW-1:0];
            node_total <= node_total + NW'(1);
            len_q      <= n_rlen;
            state      <= S_CL1;
          end
        end
        S_CL1: begin
          state <= S_CL2;
        end
        S_CL2: begin
          link_cur <= clone;
          steps    <= '0;
          state    <= S_RED;
        end
        S_RED: begin
          if (lane_valid && (lane_tgt == q) && step_ok) begin
            p     <= n_rlink;
            steps <= steps + STW'(1);
            state <= S_RRD;
          end else begin
            state <= S_DONE;
          end
        end
        S_RRD: begin
          state <= S_RED;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register, loaded only as a result is handed over.
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      new_state    <= sab_pkg::IDX_W'(cur);
      state_length <= len_cur;
      suffix_link  <= sab_pkg::IDX_W'(link_cur);
      cloned       <= made_clone;
      clone_state  <= sab_pkg::IDX_W'(clone);
      state_count  <= sab_pkg::COUNT_W'(node_total);
      overflow     <= ovf;
    end
  end

endmodule

// File: design/sab_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_checker
// Port-level checks on the results of the suffix automaton builder.
// ----------------------------------------------------------------------------
module sab_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sab_pkg::IDX_W-1:0]   new_state,
  input logic [sab_pkg::IDX_W-1:0]   suffix_link,
  input logic                        cloned,
  input logic [sab_pkg::IDX_W-1:0]   clone_state,
  input logic [sab_pkg::COUNT_W-1:0] state_count,
  input logic                        overflow
);

  // An ignored letter reports no state and no clone.
  a_ovf_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> new_state == '0 && !cloned && clone_state == '0)
    else $error("overflow result carries state data");

  // The count after a step is the new state plus one, plus the clone.
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !overflow |->
      state_count[sab_pkg::IDX_W-1:0] ==
        sab_pkg::IDX_W'(new_state + sab_pkg::IDX_W'(1) + sab_pkg::IDX_W'(cloned)))
    else $error("state count disagrees with allocated states");

  // A clone follows the new state and becomes its suffix link.
  a_clone: assert property (@(posedge clk) disable iff (rst)
    out_valid && cloned |->
      clone_state == sab_pkg::IDX_W'(new_state + sab_pkg::IDX_W'(1)) &&
      suffix_link == clone_state)
    else $error("clone index or link wrong");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_state) && $stable(state_count))
    else $error("result changed while stalled");

endmodule

bind suffix_automaton_builder sab_checker u_sab_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .new_state   (new_state),
  .suffix_link (suffix_link),
  .cloned      (cloned),
  .clone_state (clone_state),
  .state_count (state_count),
  .overflow    (overflow)
);
